>>> sv/obcc_pkg.sv
// obcc_pkg: widths, codes and constants shared by the oriented box clearance core
// no dependencies; compiled first
`default_nettype none

package obcc_pkg;

  // port and register widths
  localparam int PT_W       = 32;  // point and centre coordinates, Q15.16
  localparam int CS_W       = 18;  // cos / sin, Q1.16
  localparam int EXT_W      = 31;  // half extents, buffer, reciprocal
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int VAL_W      = 2;
  localparam int COST_W     = 31;
  localparam int GRAD_W     = 14;

  // internal datapath widths
  localparam int DX_W    = PT_W + 1;      // point minus centre
  localparam int PROD_W  = DX_W + CS_W;   // rotation products
  localparam int SUM_W   = PROD_W + 1;    // sum of two products
  localparam int P_W     = SUM_W - 16;    // local coordinate after floor
  localparam int V_W     = P_W + 1;       // |p| minus half extent
  localparam int ICAND_W = 32;            // inside-box cost before saturation
  localparam int SQ_W    = 2 * EXT_W;     // d*d and d*reciprocal
  localparam int DEN_W   = EXT_W + 1;     // 2*buffer
  localparam int QUO_W   = 30;            // band cost stays at or below buffer/2
  localparam int GM_W    = 17;            // clamped gradient magnitude, up to 1.0
  localparam int SM_W    = 13;            // gradient magnitude times 0.1
  localparam int SCL_W   = GM_W + SM_W;

  localparam logic [GM_W-1:0]   ONE_Q16    = 17'd65536;
  localparam logic [SM_W-1:0]   TENTH_Q16  = 13'd6554;
  localparam logic [15:0]       ROUND_HALF = 16'd32768;
  localparam logic [COST_W-1:0] COST_MAX   = '1;

  typedef enum logic [VAL_W-1:0] {
    VAL_INVALID = 2'd0,
    VAL_AT_RISK = 2'd1,
    VAL_VALID   = 2'd2
  } validity_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X    = 3'd0,
    REG_CENTER_Y    = 3'd1,
    REG_COS_ANGLE   = 3'd2,
    REG_SIN_ANGLE   = 3'd3,
    REG_HALF_WIDTH  = 3'd4,
    REG_HALF_HEIGHT = 3'd5,
    REG_BUFFER_SIZE = 3'd6,
    REG_BUFFER_RECIP = 3'd7
  } cfg_reg_e;

endpackage

`default_nettype wire

>>> sv/obcc_if.sv
// obcc_point_if and obcc_result_if: valid/ready channels of the clearance core
// depends on obcc_pkg for field widths
`default_nettype none

interface obcc_point_if;
  import obcc_pkg::*;

  logic                   valid;
  logic                   ready;
  logic signed [PT_W-1:0] point_x;
  logic signed [PT_W-1:0] point_y;

  modport source (output valid, output point_x, output point_y, input ready);
  modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

interface obcc_result_if;
  import obcc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [VAL_W-1:0]         validity;
  logic [COST_W-1:0]        cost;
  logic signed [GRAD_W-1:0] grad_x;
  logic signed [GRAD_W-1:0] grad_y;

  modport source (output valid, output validity, output cost, output grad_x,
                  output grad_y, input ready);
  modport sink   (input valid, input validity, input cost, input grad_x,
                  input grad_y, output ready);
endinterface

`default_nettype wire

>>> sv/obcc_div.sv
// obcc_div: pipelined restoring divider, one quotient bit per stage
// depends on obcc_pkg; stage enables come from the owner's valid chain
`default_nettype none

module obcc_div (
  input  wire logic                       clk_i,
  input  wire logic [obcc_pkg::QUO_W-1:0] en_i,
  input  wire logic [obcc_pkg::SQ_W-1:0]  num_i,
  input  wire logic [obcc_pkg::DEN_W-1:0] den_i,
  output logic      [obcc_pkg::QUO_W-1:0] quo_o
);
  import obcc_pkg::*;

  logic [SQ_W-1:0]  rem_q [QUO_W];
  logic [QUO_W-1:0] quo_q [QUO_W];
  logic [DEN_W-1:0] den_q [QUO_W];

  for (genvar j = 0; j < QUO_W; j++) begin : g_stage
    localparam int BIT = QUO_W - 1 - j;

    logic [SQ_W-1:0]  rem_in, trial, rem_d;
    logic [QUO_W-1:0] quo_in, quo_d;
    logic [DEN_W-1:0] den_in;
    logic             take;

    if (j == 0) begin : g_first
      assign rem_in = num_i;
      assign quo_in = '0;
      assign den_in = den_i;
    end else begin : g_rest
      assign rem_in = rem_q[j-1];
      assign quo_in = quo_q[j-1];
      assign den_in = den_q[j-1];
    end

    always_comb begin
      trial      = SQ_W'(den_in) << BIT;
      take       = (rem_in >= trial);
      rem_d      = take ? (rem_in - trial) : rem_in;
      quo_d      = quo_in;
      quo_d[BIT] = take;
    end

    always_ff @(posedge clk_i) begin
      if (en_i[j]) begin
        rem_q[j] <= rem_d;
        quo_q[j] <= quo_d;
        den_q[j] <= den_in;
      end
    end
  end

  assign quo_o = quo_q[QUO_W-1];

endmodule

`default_nettype wire

>>> sv/oriented_box_clearance_cost_core.sv
// oriented_box_clearance_cost_core: clearance check of a point against a rotated box
// depends on obcc_pkg, obcc_point_if / obcc_result_if and obcc_div
//
// usage
//   pt_i carries one query point (point_x, point_y, Q15.16) per item; res_o returns
//   one item per point: validity (invalid / at risk / valid), a saturating cost and
//   the local-frame gradient times 0.1. cfg_we_i / cfg_idx_i / cfg_data_i write the
//   box registers; write them only while no item is in flight.
// timing
//   39 register stages: 8 front stages (offset, rotate, floor, fold, classify, multiply,
//   round, scale), 30 stages of a one-bit-per-stage divider for the band cost
//   d*d/(2*buffer), and the output register. one item per cycle while res_o.ready
//   is high.
// stall
//   each stage moves when it is empty or the stage after it moves, so bubbles
//   close up behind a stalled receiver; pt_i.ready drops only when every stage
//   holds an item and res_o.ready is low. nothing is dropped or repeated.
// reset
//   rst_ni clears all valid bits and loads the box defaults: centre 0, no rotation,
//   half extents 1.0, buffer 0.1 with reciprocal 10.0.
`default_nettype none

module oriented_box_clearance_cost_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  obcc_point_if.sink                          pt_i,
  obcc_result_if.source                       res_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [obcc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [obcc_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import obcc_pkg::*;

  localparam int FRONT_N = 8;
  localparam int OUT_IDX = FRONT_N + QUO_W;
  localparam int STG_N   = OUT_IDX + 1;

  // per-item control and gradient data that rides along the divider
  typedef struct packed {
    validity_e                 validity;
    logic                      beyond;   // some axis lies past the buffer band
    logic [1:0]                in_box;   // axis is inside the box
    logic [1:0]                gneg;     // gradient sign per axis
    logic [1:0]                pzero;    // local coordinate is exactly zero
    logic [1:0][ICAND_W-1:0]   icand;    // inside-box cost per axis
    logic [1:0][SM_W-1:0]      smag;     // scaled gradient magnitude per axis
  } side_t;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic signed [PT_W-1:0] cx_q, cy_q;
  logic signed [CS_W-1:0] cos_q, sin_q;
  logic [EXT_W-1:0]       hw_q, hh_q, bsz_q, brc_q;
  logic [EXT_W-1:0]       ext [2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q  <= '0;
      cy_q  <= '0;
      cos_q <= 18'sd65536;
      sin_q <= '0;
      hw_q  <= 31'd65536;
      hh_q  <= 31'd65536;
      bsz_q <= 31'd6554;
      brc_q <= 31'd655360;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_CENTER_X:     cx_q  <= cfg_data_i;
        REG_CENTER_Y:     cy_q  <= cfg_data_i;
        REG_COS_ANGLE:    cos_q <= cfg_data_i[CS_W-1:0];
        REG_SIN_ANGLE:    sin_q <= cfg_data_i[CS_W-1:0];
        REG_HALF_WIDTH:   hw_q  <= cfg_data_i[EXT_W-1:0];
        REG_HALF_HEIGHT:  hh_q  <= cfg_data_i[EXT_W-1:0];
        REG_BUFFER_SIZE:  bsz_q <= cfg_data_i[EXT_W-1:0];
        REG_BUFFER_RECIP: brc_q <= cfg_data_i[EXT_W-1:0];
        default: ;
      endcase
    end
  end

  assign ext[0] = hw_q;
  assign ext[1] = hh_q;

  // ---------------------------------------------------------------------------
  // valid chain: a stage loads when it is empty or the stage after it moves
  // ---------------------------------------------------------------------------
  logic [STG_N-1:0] vld_q, en;

  for (genvar k = 0; k < STG_N; k++) begin : g_en
    assign en[k] = res_o.ready | ~(&vld_q[STG_N-1:k]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= (vld_q & ~en) | ({vld_q[STG_N-2:0], pt_i.valid} & en);
    end
  end

  assign pt_i.ready = en[0];

  // ---------------------------------------------------------------------------
  // stage 1: offset from the box centre
  // ---------------------------------------------------------------------------
  logic signed [DX_W-1:0] dx_q, dy_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      dx_q <= DX_W'(pt_i.point_x) - DX_W'(cx_q);
      dy_q <= DX_W'(pt_i.point_y) - DX_W'(cy_q);
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: rotation products
  // ---------------------------------------------------------------------------
  logic signed [PROD_W-1:0] mcx_q, msy_q, mcy_q, msx_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      mcx_q <= PROD_W'(cos_q) * PROD_W'(dx_q);
      msy_q <= PROD_W'(sin_q) * PROD_W'(dy_q);
      mcy_q <= PROD_W'(cos_q) * PROD_W'(dy_q);
      msx_q <= PROD_W'(sin_q) * PROD_W'(dx_q);
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: sum and floor to Q19.16 local coordinates
  // ---------------------------------------------------------------------------
  logic signed [SUM_W-1:0] sum_x, sum_y;
  logic signed [P_W-1:0]   p_q [2];

  always_comb begin
    sum_x = SUM_W'(mcx_q) + SUM_W'(msy_q);
    sum_y = SUM_W'(mcy_q) - SUM_W'(msx_q);
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      p_q[0] <= P_W'(sum_x >>> 16);
      p_q[1] <= P_W'(sum_y >>> 16);
    end
  end

  // ---------------------------------------------------------------------------
  // stage 4: fold to |p| and subtract the half extent
  // ---------------------------------------------------------------------------
  logic [P_W-1:0]        a_abs [2];
  logic signed [V_W-1:0] v_d [2], v_q [2];
  logic [1:0]            pneg4_q, pz4_q;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      a_abs[i] = p_q[i][P_W-1] ? P_W'(-p_q[i]) : P_W'(p_q[i]);
      v_d[i]   = $signed({1'b0, a_abs[i]}) - $signed({{(V_W-EXT_W){1'b0}}, ext[i]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      for (int i = 0; i < 2; i++) begin
        v_q[i]     <= v_d[i];
        pneg4_q[i] <= p_q[i][P_W-1];
        pz4_q[i]   <= (p_q[i] == '0);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 5: classify each axis, validity, band depth and inside cost
  // ---------------------------------------------------------------------------
  logic signed [V_W-1:0] b_ext;
  logic [1:0]            ge_hi, ge_lo;
  side_t                 side5_d, side5_q;
  logic [EXT_W-1:0]      d_d [2], d_q [2];

  always_comb begin
    b_ext   = $signed({{(V_W-EXT_W){1'b0}}, bsz_q});
    side5_d = '0;
    for (int i = 0; i < 2; i++) begin
      ge_lo[i]             = ~v_q[i][V_W-1];
      ge_hi[i]             = (v_q[i] >= b_ext);
      d_d[i]               = bsz_q - v_q[i][EXT_W-1:0];
      side5_d.in_box[i]    = v_q[i][V_W-1];
      // band gradient follows sign(p), inside-box gradient opposes it
      side5_d.gneg[i]      = v_q[i][V_W-1] ? (~pneg4_q[i] & ~pz4_q[i]) : pneg4_q[i];
      side5_d.pzero[i]     = pz4_q[i];
      side5_d.icand[i]     = {2'b00, bsz_q[EXT_W-1:1]} - v_q[i][ICAND_W-1:0];
    end
    side5_d.beyond = |ge_hi;
    if (|ge_hi) begin
      side5_d.validity = VAL_VALID;
    end else if (|ge_lo) begin
      side5_d.validity = VAL_AT_RISK;
    end else begin
      side5_d.validity = VAL_INVALID;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      side5_q <= side5_d;
      d_q[0]  <= d_d[0];
      d_q[1]  <= d_d[1];
    end
  end

  // ---------------------------------------------------------------------------
  // stage 6: d*d for the band cost, d*reciprocal for the band gradient
  // ---------------------------------------------------------------------------
  side_t           side6_q;
  logic [SQ_W-1:0] sq6_q [2], gr6_q [2];

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      side6_q <= side5_q;
      for (int i = 0; i < 2; i++) begin
        sq6_q[i] <= SQ_W'(d_q[i]) * SQ_W'(d_q[i]);
        gr6_q[i] <= SQ_W'(d_q[i]) * SQ_W'(brc_q);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 7: round the band gradient and clamp it to 1.0; inside-box axes take 1.0
  // ---------------------------------------------------------------------------
  side_t                  side7_q;
  logic [SQ_W-1:0]        sq7_q [2];
  logic [SQ_W-1:0]        gr_rnd [2];
  logic [SQ_W-17:0]       gm_full [2];
  logic [GM_W-1:0]        mag_d [2], mag7_q [2];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      gr_rnd[i]  = gr6_q[i] + SQ_W'(ROUND_HALF);
      gm_full[i] = gr_rnd[i][SQ_W-1:16];
      if (side6_q.in_box[i] || (gm_full[i] > (SQ_W-16)'(ONE_Q16))) begin
        mag_d[i] = ONE_Q16;
      end else begin
        mag_d[i] = gm_full[i][GM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      side7_q <= side6_q;
      for (int i = 0; i < 2; i++) begin
        sq7_q[i]  <= sq6_q[i];
        mag7_q[i] <= mag_d[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 8: gradient times 0.1, half rounded up, zero where p is zero; divisor 2*buffer
  // ---------------------------------------------------------------------------
  side_t            side8_d, side8_q;
  logic [SQ_W-1:0]  sq8_q [2];
  logic [DEN_W-1:0] den8_q;
  logic [SCL_W-1:0] scl [2];

  always_comb begin
    side8_d = side7_q;
    for (int i = 0; i < 2; i++) begin
      scl[i] = SCL_W'(mag7_q[i]) * SCL_W'(TENTH_Q16) + SCL_W'(ROUND_HALF);
      side8_d.smag[i] = side7_q.pzero[i] ? '0 : scl[i][16 +: SM_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      side8_q  <= side8_d;
      sq8_q[0] <= sq7_q[0];
      sq8_q[1] <= sq7_q[1];
      den8_q   <= {bsz_q, 1'b0};
    end
  end

  // ---------------------------------------------------------------------------
  // band cost floor(d*d / (2*buffer)) per axis, with side data alongside
  // ---------------------------------------------------------------------------
  logic [QUO_W-1:0] quo [2];
  side_t            sd_q [QUO_W];

  for (genvar i = 0; i < 2; i++) begin : g_div
    obcc_div u_div (
      .clk_i (clk_i),
      .en_i  (en[FRONT_N +: QUO_W]),
      .num_i (sq8_q[i]),
      .den_i (den8_q),
      .quo_o (quo[i])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en[FRONT_N]) begin
      sd_q[0] <= side8_q;
    end
    for (int j = 1; j < QUO_W; j++) begin
      if (en[FRONT_N + j]) begin
        sd_q[j] <= sd_q[j-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output stage: pick the cheaper axis (x wins a tie), saturate, sign gradient
  // ---------------------------------------------------------------------------
  side_t                    sd_last;
  logic [ICAND_W-1:0]       cand [2];
  logic [ICAND_W-1:0]       best;
  logic                     sel;
  logic [GRAD_W-1:0]        gmag, gval;
  logic [COST_W-1:0]        cost_d;
  logic [GRAD_W-1:0]        gx_d, gy_d;

  logic [VAL_W-1:0]         val_q;
  logic [COST_W-1:0]        cost_q;
  logic [GRAD_W-1:0]        gx_q, gy_q;

  always_comb begin
    sd_last = sd_q[QUO_W-1];
    for (int i = 0; i < 2; i++) begin
      cand[i] = sd_last.in_box[i] ? sd_last.icand[i] : ICAND_W'(quo[i]);
    end
    sel  = (cand[1] < cand[0]);
    best = sel ? cand[1] : cand[0];
    gmag = {1'b0, sd_last.smag[sel]};
    gval = sd_last.gneg[sel] ? (~gmag + 1'b1) : gmag;
    if (sd_last.beyond) begin
      cost_d = '0;
      gx_d   = '0;
      gy_d   = '0;
    end else begin
      cost_d = best[ICAND_W-1] ? COST_MAX : best[COST_W-1:0];
      gx_d   = sel ? '0 : gval;
      gy_d   = sel ? gval : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[OUT_IDX]) begin
      val_q  <= sd_last.validity;
      cost_q <= cost_d;
      gx_q   <= gx_d;
      gy_q   <= gy_d;
    end
  end

  assign res_o.valid    = vld_q[OUT_IDX];
  assign res_o.validity = val_q;
  assign res_o.cost     = cost_q;
  assign res_o.grad_x   = gx_q;
  assign res_o.grad_y   = gy_q;

`ifndef SYNTHESIS
  // an empty output register must never hold off the sender
  a_ready_when_out_empty: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !vld_q[OUT_IDX] |-> pt_i.ready
  ) else $error("input stalled with an empty output register");

  // past the buffer on any axis means no cost and no gradient
  a_valid_means_zero: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.validity == VAL_VALID) |->
      (res_o.cost == '0 && res_o.grad_x == '0 && res_o.grad_y == '0)
  ) else $error("valid point with nonzero cost or gradient");

  // gradient lies along a single local axis
  a_single_axis_grad: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.grad_x == '0 || res_o.grad_y == '0)
  ) else $error("gradient on both axes");

  // a point inside the box always has a positive cost
  a_inside_has_cost: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.validity == VAL_INVALID) |-> (res_o.cost != '0)
  ) else $error("inside point with zero cost");
`endif

endmodule

`default_nettype wire
